// ----- hdl/rk4s_pkg.sv -----
// Shared types, constants and fixed-point helpers of the RK4 step engine.
package rk4s_pkg;

   // Word format: signed fixed point, FRAC_BITS fraction bits
   localparam int WORD_W    = 48;
   localparam int FRAC_BITS = 24;
   localparam int STEP_W    = 25;

   // Weighted sum k1 + 2k2 + 2k3 + k4 needs three more bits than a word
   localparam int SUM_W  = WORD_W + 3;
   localparam int WIDE_W = WORD_W + 4;
   localparam int QUO_W  = WORD_W + 1;

   // Multiplier: the word magnitude is cut in two halves, one per cycle
   localparam int SPLIT_W = WORD_W / 2;
   localparam int PART_W  = (WORD_W - SPLIT_W) + STEP_W;
   localparam int PROD_W  = WORD_W + STEP_W + 1;

   // Divide by six: one radix-16 digit per cycle, digit by reciprocal
   localparam int DIGIT_W    = 4;
   localparam int REM_W      = 3;
   localparam int DV_W       = REM_W + DIGIT_W;
   localparam int RECIP_W    = 6;
   localparam int RECIP_SH   = 8;
   localparam int DP_W       = DV_W + RECIP_W;
   localparam int DIV_DIGITS = (SUM_W + DIGIT_W) / DIGIT_W;
   localparam int DIV_W      = DIV_DIGITS * DIGIT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_DIGITS + 1);

   localparam logic [RECIP_W-1:0] RECIP_SIXTH = 6'd43;
   localparam logic [DV_W-1:0]    DIVISOR     = 7'd6;
   localparam logic [DIV_W-1:0]   SIXTH_BIAS  = DIV_W'(3);

   // RK4 stage counter
   localparam int RK_STAGES = 4;
   localparam int ITER_W    = $clog2(RK_STAGES);

   localparam int CSR_IDX_W = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [STEP_W-1:0]        step_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   localparam step_type STEP_RESET  = 25'd167772;
   localparam step_type STEP_ONE    = step_type'(1) << FRAC_BITS;
   localparam word_type SLOPE_RESET = 48'sd67108864;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE   = 2'd0,
      CSR_START_X     = 2'd1,
      CSR_START_Y     = 2'd2,
      CSR_START_SLOPE = 2'd3
   } csr_index_type;

   typedef struct packed {
      word_type value;
      logic     sat;
   } sat_word_type;

   typedef struct packed {
      logic     done;
      word_type value;
      logic     sat;
   } mulh_out_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [QUO_W-1:0] quot;
   } div_out_type;

   // Clamp a wide signed value to the word range, flag saturation
   function automatic sat_word_type clamp_wide(input wide_type v);
      sat_word_type r;
      r.sat = (v[WIDE_W-1:WORD_W-1] != {(WIDE_W-WORD_W+1){v[WIDE_W-1]}});
      if (r.sat) begin
         r.value = v[WIDE_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         r.value = v[WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic sat_word_type sat_add(input word_type a, input word_type b);
      return clamp_wide(wide_type'(a) + wide_type'(b));
   endfunction

   // Halve, round to nearest, ties away from zero
   function automatic word_type halve(input word_type v);
      logic signed [WORD_W:0] e;
      e = {v[WORD_W-1], v} + {{WORD_W{1'b0}}, ~v[WORD_W-1]};
      return e[WORD_W:1];
   endfunction

   // Right-hand side y'' = -2y' + 3y + 2x, saturated
   function automatic sat_word_type curve(input word_type x, input word_type y,
                                          input word_type d);
      wide_type xw;
      wide_type yw;
      wide_type dw;
      xw = wide_type'(x);
      yw = wide_type'(y);
      dw = wide_type'(d);
      return clamp_wide((xw <<< 1) + yw + (yw <<< 1) - (dw <<< 1));
   endfunction

endpackage

// ----- hdl/rk4s_chan_if.sv -----
// Handshake channel interfaces of the RK4 step engine.
interface rk4s_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rk4s_rsp_if import rk4s_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type x_out;
   word_type y_out;
   word_type slope_out;
   word_type curvature_out;
   logic     overflow;

   modport source (output valid, output x_out, output y_out, output slope_out,
                   output curvature_out, output overflow, input ready);
   modport sink (input valid, input x_out, input y_out, input slope_out,
                 input curvature_out, input overflow, output ready);
endinterface

// ----- hdl/rk4s_mulh.sv -----
// Shared multiply-by-step unit: two half-word partial products, round, saturate.
module rk4s_mulh import rk4s_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  word_type     operand,
   input  step_type     step,
   output mulh_out_type result
);

   typedef enum logic [3:0] {
      MUL_IDLE = 4'b0001,
      MUL_LO   = 4'b0010,
      MUL_HI   = 4'b0100,
      MUL_SUM  = 4'b1000
   } mul_state_type;

   mul_state_type state_ff, state_in;
   logic [WORD_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [PART_W-1:0] lo_ff, lo_in, hi_ff, hi_in, part_prod;
   logic [WORD_W-SPLIT_W-1:0] part;
   logic [PROD_W-1:0] full, rnd, limit, clipped;
   logic over;
   word_type value_ff, value_in;
   logic sat_ff, sat_in, done_ff, done_in;

   always_comb begin
      part = (state_ff == MUL_LO) ? (WORD_W-SPLIT_W)'(mag_ff[SPLIT_W-1:0])
                                  : mag_ff[WORD_W-1:SPLIT_W];
      part_prod = PART_W'(part) * PART_W'(step);

      full    = (PROD_W'(hi_ff) << SPLIT_W) + PROD_W'(lo_ff) + ROUND_HALF;
      rnd     = full >> FRAC_BITS;
      limit   = PROD_W'(WORD_MAX) + PROD_W'(neg_ff);
      // Full-scale negative input at a unit step lands on the limit yet counts as saturated
      over    = (rnd > limit) || (mag_ff[WORD_W-1] && (step == STEP_ONE));
      clipped = over ? limit : rnd;

      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      value_in = value_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;

      case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               neg_in   = operand[WORD_W-1];
               mag_in   = operand[WORD_W-1] ? (~operand + 1'b1) : operand;
               state_in = MUL_LO;
            end
         end
         MUL_LO: begin
            lo_in    = part_prod;
            state_in = MUL_HI;
         end
         MUL_HI: begin
            hi_in    = part_prod;
            state_in = MUL_SUM;
         end
         MUL_SUM: begin
            value_in = neg_ff ? -clipped[WORD_W-1:0] : clipped[WORD_W-1:0];
            sat_in   = over;
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
         default: begin
            state_in = MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign result.done  = done_ff;
   assign result.value = value_ff;
   assign result.sat   = sat_ff;

endmodule

// ----- hdl/rk4s_div6.sv -----
// Divide-by-six unit, rounded half away from zero, one radix-16 digit a cycle.
module rk4s_div6 import rk4s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  sum_type     dividend,
   output div_out_type result
);

   typedef enum logic [1:0] {
      DIV_IDLE = 2'b01,
      DIV_RUN  = 2'b10
   } div_state_type;

   div_state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] mag_ff, mag_in, quo_ff, quo_in, ext;
   logic neg_ff, neg_in, done_ff, done_in;
   logic [DV_W-1:0] partial, back;
   logic [DP_W-1:0] est;
   logic [DIGIT_W-1:0] digit;

   always_comb begin
      ext     = DIV_W'(dividend);
      partial = {rem_ff, mag_ff[DIV_W-1 -: DIGIT_W]};
      est     = DP_W'(partial) * DP_W'(RECIP_SIXTH);
      digit   = est[RECIP_SH +: DIGIT_W];
      back    = partial - DV_W'(digit) * DIVISOR;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      mag_in   = mag_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;

      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in   = dividend[SUM_W-1];
               mag_in   = (dividend[SUM_W-1] ? -ext : ext) + SIXTH_BIAS;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = DIV_CNT_W'(DIV_DIGITS);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in = back[REM_W-1:0];
            mag_in = mag_ff << DIGIT_W;
            quo_in = {quo_ff[DIV_W-DIGIT_W-1:0], digit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign result.done = done_ff;
   assign result.neg  = neg_ff;
   assign result.quot = quo_ff[QUO_W-1:0];

endmodule

// ----- hdl/rk4_second_order_ode_step.sv -----
// Top level of the RK4 step engine: sequencer, state and datapath registers.
//
// Integrates y'' = -2y' + 3y + 2x with the classical fourth-order Runge-Kutta
// method in signed 48-bit Q24.24 words. A request transaction with restart set
// loads x, y and y' from the start registers and returns that point; one with
// restart clear advances the state by one step of h and returns the new x, y,
// y', the curvature y'' evaluated at the new point, and an overflow flag that
// is set when any intermediate or final value saturated during that item. The
// block handles one item at a time and holds req ready low while busy, and it
// is ready again in the cycle after the response transaction. The step time is
// set by the eight products with h on the single shared 24x25-bit multiplier
// and by the two divisions by six of the weighted sums in the digit-serial
// divider. Write the configuration registers only while idle.
module rk4_second_order_ode_step import rk4s_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rk4s_req_if.sink             req_bus,
   rk4s_rsp_if.source           rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  word_type             csr_wdata
);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_LOAD    = 14'b00000000000010,
      ST_PREP    = 14'b00000000000100,
      ST_CURV    = 14'b00000000001000,
      ST_K_GO    = 14'b00000000010000,
      ST_K_WAIT  = 14'b00000000100000,
      ST_M_GO    = 14'b00000001000000,
      ST_M_WAIT  = 14'b00000010000000,
      ST_DY_GO   = 14'b00000100000000,
      ST_DY_WAIT = 14'b00001000000000,
      ST_DD_GO   = 14'b00010000000000,
      ST_DD_WAIT = 14'b00100000000000,
      ST_FINAL   = 14'b01000000000000,
      ST_OUT     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   step_type step_ff, step_in;
   word_type sx_ff, sx_in, sy_ff, sy_in, sd_ff, sd_in;

   // Integrator state: x, y, y'
   word_type x_ff, x_in, y_ff, y_in, d_ff, d_in;

   // Working registers of one step
   word_type xm_ff, xm_in, xe_ff, xe_in;
   word_type ycur_ff, ycur_in, dcur_ff, dcur_in;
   word_type f_ff, f_in, k_ff, k_in;
   sum_type  ksum_ff, ksum_in, msum_ff, msum_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic sat_ff, sat_in;

   // Shared units
   mulh_out_type mul_res;
   div_out_type  div_res;
   logic     mul_start, div_start;
   word_type mul_opnd;
   sum_type  div_opnd;

   // Datapath helpers
   logic [STEP_W:0] step_rnd;
   sat_word_type xm_sat, xe_sat, curv_sat, ynext_sat, dnext_sat, fin_sat;
   word_type cx, cy, cd, base;
   sum_type  prod_ext, prod_add, acc_base;
   wide_type quot_ext;
   logic     dbl, last, accept;

   rk4s_mulh u_mulh (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_opnd),
      .step    (step_ff),
      .result  (mul_res)
   );

   rk4s_div6 u_div6 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_opnd),
      .result   (div_res)
   );

   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      // x at mid step and end of step
      step_rnd = (STEP_W+1)'(step_ff) + (STEP_W+1)'(1);
      xm_sat   = clamp_wide(wide_type'(x_ff) + wide_type'(step_rnd[STEP_W:1]));
      xe_sat   = clamp_wide(wide_type'(x_ff) + wide_type'(step_ff));

      // One curvature evaluator: stage point, or the emitted point at the end
      if (state_ff == ST_FINAL) begin
         cx = x_ff;
         cy = y_ff;
         cd = d_ff;
      end else begin
         cx = (iter_ff == '0) ? x_ff
            : (iter_ff == ITER_W'(RK_STAGES - 1)) ? xe_ff : xm_ff;
         cy = ycur_ff;
         cd = dcur_ff;
      end
      curv_sat = curve(cx, cy, cd);

      // Weighted accumulation: stages two and three count twice
      dbl      = (iter_ff == ITER_W'(1)) || (iter_ff == ITER_W'(2));
      last     = (iter_ff == ITER_W'(RK_STAGES - 2));
      prod_ext = sum_type'(mul_res.value);
      prod_add = dbl ? (prod_ext <<< 1) : prod_ext;
      acc_base = (state_ff == ST_K_WAIT) ? ksum_ff : msum_ff;

      // Next stage arguments; the final stage takes full rather than half terms
      ynext_sat = sat_add(y_ff, last ? k_ff : halve(k_ff));
      dnext_sat = sat_add(d_ff, last ? mul_res.value : halve(mul_res.value));

      // Old value plus or minus the sixth of the weighted sum
      base     = (state_ff == ST_DY_WAIT) ? y_ff : d_ff;
      quot_ext = wide_type'(div_res.quot);
      fin_sat  = clamp_wide(div_res.neg ? (wide_type'(base) - quot_ext)
                                        : (wide_type'(base) + quot_ext));

      mul_start = (state_ff == ST_K_GO) || (state_ff == ST_M_GO);
      mul_opnd  = (state_ff == ST_K_GO) ? dcur_ff : f_ff;
      div_start = (state_ff == ST_DY_GO) || (state_ff == ST_DD_GO);
      div_opnd  = (state_ff == ST_DY_GO) ? ksum_ff : msum_ff;
   end

   // Configuration writes
   always_comb begin
      step_in = step_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sd_in   = sd_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_SIZE:   step_in = csr_wdata[STEP_W-1:0];
            CSR_START_X:     sx_in   = csr_wdata;
            CSR_START_Y:     sy_in   = csr_wdata;
            CSR_START_SLOPE: sd_in   = csr_wdata;
            default:         step_in = step_ff;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      xm_in    = xm_ff;
      xe_in    = xe_ff;
      ycur_in  = ycur_ff;
      dcur_in  = dcur_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      ksum_in  = ksum_ff;
      msum_in  = msum_ff;
      iter_in  = iter_ff;
      sat_in   = sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sat_in   = 1'b0;
               state_in = req_bus.restart ? ST_LOAD : ST_PREP;
            end
         end
         ST_LOAD: begin
            x_in     = sx_ff;
            y_in     = sy_ff;
            d_in     = sd_ff;
            state_in = ST_FINAL;
         end
         ST_PREP: begin
            xm_in    = xm_sat.value;
            xe_in    = xe_sat.value;
            sat_in   = sat_ff | xm_sat.sat | xe_sat.sat;
            ycur_in  = y_ff;
            dcur_in  = d_ff;
            ksum_in  = '0;
            msum_in  = '0;
            iter_in  = '0;
            state_in = ST_CURV;
         end
         ST_CURV: begin
            f_in     = curv_sat.value;
            sat_in   = sat_ff | curv_sat.sat;
            state_in = ST_K_GO;
         end
         ST_K_GO: begin
            state_in = ST_K_WAIT;
         end
         ST_K_WAIT: begin
            if (mul_res.done) begin
               k_in     = mul_res.value;
               ksum_in  = acc_base + prod_add;
               sat_in   = sat_ff | mul_res.sat;
               state_in = ST_M_GO;
            end
         end
         ST_M_GO: begin
            state_in = ST_M_WAIT;
         end
         ST_M_WAIT: begin
            if (mul_res.done) begin
               msum_in = acc_base + prod_add;
               if (iter_ff == ITER_W'(RK_STAGES - 1)) begin
                  sat_in   = sat_ff | mul_res.sat;
                  state_in = ST_DY_GO;
               end else begin
                  // Advance to the next stage's y and y'
                  ycur_in  = ynext_sat.value;
                  dcur_in  = dnext_sat.value;
                  sat_in   = sat_ff | mul_res.sat | ynext_sat.sat | dnext_sat.sat;
                  iter_in  = iter_ff + 1'b1;
                  state_in = ST_CURV;
               end
            end
         end
         ST_DY_GO: begin
            x_in     = xe_ff;
            state_in = ST_DY_WAIT;
         end
         ST_DY_WAIT: begin
            if (div_res.done) begin
               y_in     = fin_sat.value;
               sat_in   = sat_ff | fin_sat.sat;
               state_in = ST_DD_GO;
            end
         end
         ST_DD_GO: begin
            state_in = ST_DD_WAIT;
         end
         ST_DD_WAIT: begin
            if (div_res.done) begin
               d_in     = fin_sat.value;
               sat_in   = sat_ff | fin_sat.sat;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            f_in     = curv_sat.value;
            sat_in   = sat_ff | curv_sat.sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold the result until the response transaction completes
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_RESET;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sd_ff    <= SLOPE_RESET;
         x_ff     <= '0;
         y_ff     <= '0;
         d_ff     <= '0;
         iter_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sd_ff    <= sd_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         d_ff     <= d_in;
         iter_ff  <= iter_in;
         sat_ff   <= sat_in;
      end
      xm_ff   <= xm_in;
      xe_ff   <= xe_in;
      ycur_ff <= ycur_in;
      dcur_ff <= dcur_in;
      f_ff    <= f_in;
      k_ff    <= k_in;
      ksum_ff <= ksum_in;
      msum_ff <= msum_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = (state_ff == ST_OUT);
   assign rsp_bus.x_out         = x_ff;
   assign rsp_bus.y_out         = y_ff;
   assign rsp_bus.slope_out     = d_ff;
   assign rsp_bus.curvature_out = f_ff;
   assign rsp_bus.overflow      = sat_ff;

   // Never take a request while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request taken while a response is pending");

   // A product may only land while the sequencer waits for it
   a_mul_expected: assert property (@(posedge clock) disable iff (reset)
      mul_res.done |-> (state_ff == ST_K_WAIT || state_ff == ST_M_WAIT))
      else $error("multiplier result arrived outside a wait state");

   // A quotient may only land while the sequencer waits for it
   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DY_WAIT || state_ff == ST_DD_WAIT))
      else $error("divider result arrived outside a wait state");

   // A restart transaction loads the start point on the next cycle
   a_restart_load: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.restart) |=> (state_ff == ST_LOAD))
      else $error("restart did not load the start point");

endmodule
